>>> sv/diameter_message_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef DIAMETER_MESSAGE_DEFRAMER_DEFINES_SVH
`define DIAMETER_MESSAGE_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled in reset
`define DMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

>>> sv/dmd_pkg.sv
// Shared types and constants for the Diameter message deframer.
// No dependencies.
package dmd_pkg;

    localparam logic [6:0] MAX_AVPS = 7'd64;

    typedef enum logic [3:0] {
        KIND_NONE       = 4'd0,
        KIND_VERSION    = 4'd1,
        KIND_MSG_LENGTH = 4'd2,
        KIND_FLAGS      = 4'd3,
        KIND_COMMAND    = 4'd4,
        KIND_APP_ID     = 4'd5,
        KIND_HOP_ID     = 4'd6,
        KIND_E2E_ID     = 4'd7,
        KIND_AVP_CODE   = 4'd8,
        KIND_AVP_FLAGS  = 4'd9,
        KIND_AVP_LENGTH = 4'd10,
        KIND_VENDOR_ID  = 4'd11,
        KIND_DATA       = 4'd12,
        KIND_ERROR      = 4'd13
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_MSG_SHORT   = 2'd1,
        ERR_AVP_SHORT   = 2'd2,
        ERR_AVP_OVERRUN = 2'd3
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [6:0]  avp_number;
        logic        end_of_avp;
        logic        end_of_message;
        t_err        err;
    } t_result;

endpackage

>>> sv/dmd_parser.sv
// Per-byte Diameter framing state and registered result.
// Depends on dmd_pkg and diameter_message_deframer_defines.svh.
`include "diameter_message_deframer_defines.svh"

module dmd_parser #(
    parameter logic [6:0] MAX_AVPS = dmd_pkg::MAX_AVPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_data_byte,
    input  logic             i_first_byte,
    output dmd_pkg::t_result o_result
);
    import dmd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_AVP, PH_DATA, PH_PAD, PH_SKIPMSG, PH_SKIPALL
    } t_phase;

    localparam logic [23:0] HDR_VERSION_POS = 24'd0;
    localparam logic [23:0] HDR_LEN_END     = 24'd3;
    localparam logic [23:0] HDR_FLAGS_POS   = 24'd4;
    localparam logic [23:0] HDR_CMD_END     = 24'd7;
    localparam logic [23:0] HDR_APP_END     = 24'd11;
    localparam logic [23:0] HDR_HOP_END     = 24'd15;
    localparam logic [23:0] HDR_E2E_END     = 24'd19;
    localparam logic [23:0] HDR_LEN         = 24'd20;
    localparam logic [23:0] AVP_CODE_END    = 24'd3;
    localparam logic [23:0] AVP_FLAGS_POS   = 24'd4;
    localparam logic [23:0] AVP_LEN_END     = 24'd7;
    localparam logic [23:0] AVP_VENDOR_END  = 24'd11;
    localparam logic [23:0] AVP_MIN_LEN     = 24'd8;
    localparam logic [23:0] AVP_MIN_LEN_VND = 24'd12;
    localparam int          VENDOR_BIT      = 7;

    t_phase      r_phase, n_phase, cur_phase;
    logic [23:0] r_msg_cnt, n_msg_cnt, cur_msg_cnt;
    logic [23:0] r_msg_len, n_msg_len, cur_msg_len;
    logic [31:0] r_shift, n_shift, cur_shift;
    logic [23:0] r_avp_cnt, n_avp_cnt, cur_avp_cnt;
    logic [23:0] r_avp_len, n_avp_len, cur_avp_len;
    logic [7:0]  r_avp_flags, n_avp_flags, cur_avp_flags;
    logic [6:0]  r_avp_ctr, n_avp_ctr, cur_avp_ctr;
    t_result     r_result, n_result;

    logic [24:0] msg_cnt_p1;
    logic [24:0] avp_cnt_p1;
    logic [23:0] min_len;
    logic [1:0]  pad_cur;
    logic [1:0]  pad_new;
    logic        done;
    logic        fin;

    always_comb begin
        cur_phase     = i_first_byte ? PH_HDR : r_phase;
        cur_msg_cnt   = i_first_byte ? '0 : r_msg_cnt;
        cur_msg_len   = i_first_byte ? '0 : r_msg_len;
        cur_shift     = i_first_byte ? '0 : r_shift;
        cur_avp_cnt   = i_first_byte ? '0 : r_avp_cnt;
        cur_avp_len   = i_first_byte ? '0 : r_avp_len;
        cur_avp_flags = i_first_byte ? '0 : r_avp_flags;
        cur_avp_ctr   = i_first_byte ? '0 : r_avp_ctr;

        n_phase     = cur_phase;
        n_msg_cnt   = cur_msg_cnt;
        n_msg_len   = cur_msg_len;
        n_shift     = cur_shift;
        n_avp_cnt   = cur_avp_cnt;
        n_avp_len   = cur_avp_len;
        n_avp_flags = cur_avp_flags;
        n_avp_ctr   = cur_avp_ctr;

        n_result.kind           = KIND_NONE;
        n_result.value          = '0;
        n_result.avp_number     = '0;
        n_result.end_of_avp     = 1'b0;
        n_result.end_of_message = 1'b0;
        n_result.err            = ERR_NONE;

        msg_cnt_p1 = {1'b0, cur_msg_cnt} + 25'd1;
        avp_cnt_p1 = {1'b0, cur_avp_cnt} + 25'd1;
        min_len    = cur_avp_flags[VENDOR_BIT] ? AVP_MIN_LEN_VND : AVP_MIN_LEN;
        pad_cur    = 2'd0 - cur_avp_len[1:0];
        pad_new    = 2'd0;
        done       = 1'b0;
        fin        = 1'b0;

        if (cur_phase != PH_IDLE && cur_phase != PH_SKIPALL) begin
            n_shift   = {cur_shift[23:0], i_data_byte};
            n_msg_cnt = msg_cnt_p1[23:0];

            unique case (cur_phase)
                PH_HDR: begin
                    unique case (cur_msg_cnt)
                        HDR_VERSION_POS: begin
                            n_result.kind  = KIND_VERSION;
                            n_result.value = {24'd0, i_data_byte};
                        end
                        HDR_LEN_END: begin
                            n_msg_len      = n_shift[23:0];
                            n_result.kind  = KIND_MSG_LENGTH;
                            n_result.value = {8'd0, n_shift[23:0]};
                            if (n_shift[23:0] < HDR_LEN) begin
                                n_result.kind = KIND_ERROR;
                                n_result.err  = ERR_MSG_SHORT;
                                n_phase       = PH_SKIPALL;
                            end
                        end
                        HDR_FLAGS_POS: begin
                            n_result.kind  = KIND_FLAGS;
                            n_result.value = {24'd0, i_data_byte};
                        end
                        HDR_CMD_END: begin
                            n_result.kind  = KIND_COMMAND;
                            n_result.value = {8'd0, n_shift[23:0]};
                        end
                        HDR_APP_END: begin
                            n_result.kind  = KIND_APP_ID;
                            n_result.value = n_shift;
                        end
                        HDR_HOP_END: begin
                            n_result.kind  = KIND_HOP_ID;
                            n_result.value = n_shift;
                        end
                        HDR_E2E_END: begin
                            n_result.kind  = KIND_E2E_ID;
                            n_result.value = n_shift;
                            n_phase        = PH_AVP;
                            n_avp_cnt      = '0;
                        end
                        default: ;
                    endcase
                end
                PH_AVP: begin
                    n_avp_cnt = avp_cnt_p1[23:0];
                    if (cur_avp_cnt == AVP_CODE_END) begin
                        n_result.kind  = KIND_AVP_CODE;
                        n_result.value = n_shift;
                    end else if (cur_avp_cnt == AVP_FLAGS_POS) begin
                        n_avp_flags    = i_data_byte;
                        n_result.kind  = KIND_AVP_FLAGS;
                        n_result.value = {24'd0, i_data_byte};
                    end else if (cur_avp_cnt == AVP_LEN_END) begin
                        n_avp_len      = n_shift[23:0];
                        n_result.kind  = KIND_AVP_LENGTH;
                        n_result.value = {8'd0, n_shift[23:0]};
                        if (n_shift[23:0] < min_len) begin
                            n_result.err = ERR_AVP_SHORT;
                        end else if (({1'b0, cur_msg_cnt} + {1'b0, n_shift[23:0]}) >
                                     ({1'b0, cur_msg_len} + {1'b0, AVP_LEN_END})) begin
                            n_result.err = ERR_AVP_OVERRUN;
                        end
                        if (n_result.err != ERR_NONE) begin
                            n_result.kind = KIND_ERROR;
                            n_phase       = PH_SKIPMSG;
                        end else if (!cur_avp_flags[VENDOR_BIT]) begin
                            done = 1'b1;
                        end
                    end else if (cur_avp_cnt == AVP_VENDOR_END) begin
                        n_result.kind  = KIND_VENDOR_ID;
                        n_result.value = n_shift;
                        done           = 1'b1;
                    end
                    if (done) begin
                        if (avp_cnt_p1 == {1'b0, n_avp_len}) begin
                            n_result.end_of_avp = 1'b1;
                            fin                 = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_result.kind  = KIND_DATA;
                    n_result.value = {24'd0, i_data_byte};
                    n_avp_cnt      = avp_cnt_p1[23:0];
                    if (avp_cnt_p1 == {1'b0, cur_avp_len}) begin
                        n_result.end_of_avp = 1'b1;
                        fin                 = 1'b1;
                    end
                end
                PH_PAD: begin
                    n_avp_cnt = avp_cnt_p1[23:0];
                    if (avp_cnt_p1 >= ({1'b0, cur_avp_len} + {23'd0, pad_cur})) begin
                        n_phase   = PH_AVP;
                        n_avp_cnt = '0;
                    end
                end
                default: ;
            endcase

            if (fin) begin
                pad_new = 2'd0 - n_avp_len[1:0];
                if (cur_avp_ctr < MAX_AVPS) begin
                    n_avp_ctr = cur_avp_ctr + 7'd1;
                end
                if (pad_new != 2'd0) begin
                    n_phase   = PH_PAD;
                    n_avp_cnt = avp_cnt_p1[23:0];
                end else begin
                    n_phase   = PH_AVP;
                    n_avp_cnt = '0;
                end
            end

            if (cur_phase != PH_HDR) begin
                n_result.avp_number = cur_avp_ctr;
                if (cur_avp_ctr >= MAX_AVPS && n_result.kind != KIND_ERROR) begin
                    n_result.kind       = KIND_NONE;
                    n_result.value      = '0;
                    n_result.end_of_avp = 1'b0;
                end
            end

            if (n_phase != PH_SKIPALL && msg_cnt_p1 == {1'b0, n_msg_len}) begin
                n_result.end_of_message = 1'b1;
                if (n_phase == PH_AVP && n_avp_cnt != '0 &&
                    n_result.kind != KIND_ERROR) begin
                    n_result.kind       = KIND_ERROR;
                    n_result.err        = ERR_AVP_OVERRUN;
                    n_result.value      = '0;
                    n_result.end_of_avp = 1'b0;
                end
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_msg_cnt   <= '0;
            r_msg_len   <= '0;
            r_shift     <= '0;
            r_avp_cnt   <= '0;
            r_avp_len   <= '0;
            r_avp_flags <= '0;
            r_avp_ctr   <= '0;
            r_result    <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_msg_cnt   <= n_msg_cnt;
            r_msg_len   <= n_msg_len;
            r_shift     <= n_shift;
            r_avp_cnt   <= n_avp_cnt;
            r_avp_len   <= n_avp_len;
            r_avp_flags <= n_avp_flags;
            r_avp_ctr   <= n_avp_ctr;
            r_result    <= n_result;
        end
    end

    assign o_result = r_result;

    `DMD_ASSERT_IMPL(a_err_kind, i_clk, i_rst_n, (r_result.kind == KIND_ERROR),
                     (r_result.err != ERR_NONE))
    `DMD_ASSERT_IMPL(a_eoa_kind, i_clk, i_rst_n, r_result.end_of_avp,
                     (r_result.kind == KIND_AVP_LENGTH || r_result.kind == KIND_VENDOR_ID ||
                      r_result.kind == KIND_DATA))
    `DMD_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n,
                     (r_phase == PH_IDLE && !(i_adv && i_first_byte)), (r_phase == PH_IDLE))

endmodule

>>> sv/diameter_message_deframer.sv
// Diameter message deframer, top level: input beat register, handshake, result valid.
// Depends on dmd_pkg, dmd_parser and diameter_message_deframer_defines.svh.
//
// Usage:
//   Input channel: i_valid / o_stall carry one message byte per beat
//   (i_data_byte) plus i_first_byte, which marks byte 0 of a message and
//   restarts framing at any point.
//   Output channel: o_valid / i_stall carry one tagged result per input beat
//   (o_kind, o_value, o_avp_number, o_end_of_avp, o_end_of_message,
//   o_error_code), in input order.
//   Path: a byte is accepted into the input register, then parsed into the
//   result register, from which its result is presented.
//   Throughput: one byte per cycle while the output is not stalled.
//   Reset: synchronous, active low; framing goes idle and bytes are ignored
//   (all-zero results) until a beat with i_first_byte set.
//   Stall: a stalled result holds; one more byte is absorbed by the input
//   register, after which o_stall is raised until the result is taken.
`include "diameter_message_deframer_defines.svh"

module diameter_message_deframer #(
    parameter logic [6:0] MAX_AVPS = dmd_pkg::MAX_AVPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic [31:0] o_value,
    output logic [6:0]  o_avp_number,
    output logic        o_end_of_avp,
    output logic        o_end_of_message,
    output logic [1:0]  o_error_code
);
    import dmd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_out_valid;
    logic       adv;
    t_result    w_result;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
        end
    end

    dmd_parser #(
        .MAX_AVPS (MAX_AVPS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_data_byte  (r_in_byte),
        .i_first_byte (r_in_first),
        .o_result     (w_result)
    );

    assign o_valid          = r_out_valid;
    assign o_kind           = w_result.kind;
    assign o_value          = w_result.value;
    assign o_avp_number     = w_result.avp_number;
    assign o_end_of_avp     = w_result.end_of_avp;
    assign o_end_of_message = w_result.end_of_message;
    assign o_error_code     = w_result.err;

    `DMD_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, (i_valid && !o_stall), r_in_valid)
    `DMD_ASSERT_NEXT(a_empty_out_loads, i_clk, i_rst_n, (r_in_valid && !r_out_valid), o_valid)
    `DMD_ASSERT_NEXT(a_take_refills, i_clk, i_rst_n, (r_in_valid && o_valid && !i_stall), o_valid)

endmodule

>>> dv/tb_diameter_message_deframer.sv
// Testbench for diameter_message_deframer: byte-level stimulus of Diameter messages,
// checked beat by beat against an in-bench model of the deframer or scripted values.
// Depends on dmd_pkg and the diameter_message_deframer RTL.
`timescale 1ns / 1ps

module tb_diameter_message_deframer;
    import dmd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [31:0] HDR_BYTES = 32'd20;

    typedef enum logic [2:0] {
        PH_WAIT, PH_HEADER, PH_AVP_HDR, PH_AVP_DATA, PH_AVP_PAD, PH_DROP_MSG, PH_DROP_ALL
    } t_phase;

    typedef struct packed {
        logic [7:0] b;
        logic       f;
        logic       typed;
        t_result    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_kind;
    logic [31:0] o_value;
    logic [6:0]  o_avp_number;
    logic        o_end_of_avp;
    logic        o_end_of_message;
    logic [1:0]  o_error_code;

    diameter_message_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_value         (o_value),
        .o_avp_number    (o_avp_number),
        .o_end_of_avp    (o_end_of_avp),
        .o_end_of_message(o_end_of_message),
        .o_error_code    (o_error_code)
    );

    // deframer model state
    t_phase      ph = PH_WAIT;
    logic [23:0] msg_cnt = '0;
    logic [23:0] msg_len = '0;
    logic [31:0] shreg = '0;
    logic [23:0] avp_cnt = '0;
    logic [23:0] avp_len = '0;
    logic [7:0]  avp_flags = '0;
    logic [6:0]  avp_idx = '0;

    t_result     fields_due[$];
    t_row        script[$];
    logic [7:0]  msg_bytes[$];
    int          last_pad;
    int          sent_beats = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    t_result     got;
    t_result     want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void close_avp(input logic [31:0] c);
        logic [31:0] pad;
        pad = (32'd4 - {30'd0, avp_len[1:0]}) & 32'd3;
        if (avp_idx < MAX_AVPS)
            avp_idx = avp_idx + 7'd1;
        if (pad != 0) begin
            ph = PH_AVP_PAD;
            avp_cnt = c[23:0] + 24'd1;
        end else begin
            ph = PH_AVP_HDR;
            avp_cnt = '0;
        end
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] b, input logic f);
        t_result     r;
        logic [31:0] idx, c, pad, minlen, start;
        t_phase      ph0;
        logic [6:0]  idx0;
        logic        close;
        r = '0;
        close = 1'b0;
        if (f) begin
            ph = PH_HEADER;
            msg_cnt = '0;
            msg_len = '0;
            shreg = '0;
            avp_cnt = '0;
            avp_len = '0;
            avp_flags = '0;
            avp_idx = '0;
        end
        if (ph == PH_WAIT || ph == PH_DROP_ALL)
            return r;
        shreg = {shreg[23:0], b};
        idx = {8'd0, msg_cnt};
        ph0 = ph;
        idx0 = avp_idx;
        case (ph)
            PH_HEADER: begin
                case (idx)
                    0: begin
                        r.kind = KIND_VERSION;
                        r.value = {24'd0, b};
                    end
                    3: begin
                        msg_len = shreg[23:0];
                        r.kind = KIND_MSG_LENGTH;
                        r.value = {8'd0, msg_len};
                        if ({8'd0, msg_len} < HDR_BYTES) begin
                            r.kind = KIND_ERROR;
                            r.err = ERR_MSG_SHORT;
                            ph = PH_DROP_ALL;
                        end
                    end
                    4: begin
                        r.kind = KIND_FLAGS;
                        r.value = {24'd0, b};
                    end
                    7: begin
                        r.kind = KIND_COMMAND;
                        r.value = {8'd0, shreg[23:0]};
                    end
                    11: begin
                        r.kind = KIND_APP_ID;
                        r.value = shreg;
                    end
                    15: begin
                        r.kind = KIND_HOP_ID;
                        r.value = shreg;
                    end
                    19: begin
                        r.kind = KIND_E2E_ID;
                        r.value = shreg;
                        ph = PH_AVP_HDR;
                        avp_cnt = '0;
                    end
                    default: ;
                endcase
            end
            PH_AVP_HDR: begin
                c = {8'd0, avp_cnt};
                avp_cnt = avp_cnt + 24'd1;
                if (c == 3) begin
                    r.kind = KIND_AVP_CODE;
                    r.value = shreg;
                end else if (c == 4) begin
                    avp_flags = b;
                    r.kind = KIND_AVP_FLAGS;
                    r.value = {24'd0, b};
                end else if (c == 7) begin
                    minlen = avp_flags[7] ? 32'd12 : 32'd8;
                    start = idx - 32'd7;
                    avp_len = shreg[23:0];
                    r.kind = KIND_AVP_LENGTH;
                    r.value = {8'd0, avp_len};
                    if ({8'd0, avp_len} < minlen)
                        r.err = ERR_AVP_SHORT;
                    else if (start + {8'd0, avp_len} > {8'd0, msg_len})
                        r.err = ERR_AVP_OVERRUN;
                    if (r.err != ERR_NONE) begin
                        r.kind = KIND_ERROR;
                        ph = PH_DROP_MSG;
                    end else if (!avp_flags[7]) begin
                        close = 1'b1;
                    end
                end else if (c == 11) begin
                    r.kind = KIND_VENDOR_ID;
                    r.value = shreg;
                    close = 1'b1;
                end
                if (close) begin
                    if (c + 1 == {8'd0, avp_len}) begin
                        r.end_of_avp = 1'b1;
                        close_avp(c);
                    end else begin
                        ph = PH_AVP_DATA;
                    end
                end
            end
            PH_AVP_DATA: begin
                c = {8'd0, avp_cnt};
                r.kind = KIND_DATA;
                r.value = {24'd0, b};
                avp_cnt = avp_cnt + 24'd1;
                if (c + 1 == {8'd0, avp_len}) begin
                    r.end_of_avp = 1'b1;
                    close_avp(c);
                end
            end
            PH_AVP_PAD: begin
                c = {8'd0, avp_cnt};
                pad = (32'd4 - {30'd0, avp_len[1:0]}) & 32'd3;
                avp_cnt = avp_cnt + 24'd1;
                if (c + 1 >= {8'd0, avp_len} + pad) begin
                    ph = PH_AVP_HDR;
                    avp_cnt = '0;
                end
            end
            default: ;
        endcase
        if (ph0 != PH_HEADER) begin
            r.avp_number = idx0;
            if (idx0 >= MAX_AVPS && r.kind != KIND_ERROR) begin
                r.kind = KIND_NONE;
                r.value = '0;
                r.end_of_avp = 1'b0;
            end
        end
        msg_cnt = idx[23:0] + 24'd1;
        if (ph != PH_DROP_ALL && idx + 1 == {8'd0, msg_len}) begin
            r.end_of_message = 1'b1;
            if (ph == PH_AVP_HDR && avp_cnt != '0 && r.kind != KIND_ERROR) begin
                r.kind = KIND_ERROR;
                r.err = ERR_AVP_OVERRUN;
                r.value = '0;
                r.end_of_avp = 1'b0;
            end
            ph = PH_WAIT;
        end
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic f, input logic typed,
                                    input t_kind k, input logic [31:0] v, input logic eom,
                                    input t_err e);
        t_row row;
        row = '0;
        row.b = b;
        row.f = f;
        row.typed = typed;
        row.want.kind = k;
        row.want.value = v;
        row.want.end_of_message = eom;
        row.want.err = e;
        script.push_back(row);
    endfunction

    function automatic void add_be(input logic [31:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            msg_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void set_msg_len(input logic [23:0] len);
        msg_bytes[1] = len[23:16];
        msg_bytes[2] = len[15:8];
        msg_bytes[3] = len[7:0];
    endfunction

    function automatic void start_header();
        msg_bytes.delete();
        last_pad = 0;
        add_be($urandom, 1);
        add_be(32'd0, 3);
        add_be($urandom, 1);
        add_be($urandom, 3);
        add_be($urandom, 4);
        add_be($urandom, 4);
        add_be($urandom, 4);
    endfunction

    function automatic void add_avp(input logic [23:0] len_field, input int data_len,
                                    input bit vendor);
        logic [7:0] fl;
        int         i;
        fl = 8'($urandom);
        fl[7] = vendor;
        add_be($urandom, 4);
        add_be({24'd0, fl}, 1);
        add_be({8'd0, len_field}, 3);
        if (vendor)
            add_be($urandom, 4);
        for (i = 0; i < data_len; i++)
            msg_bytes.push_back(8'($urandom));
        last_pad = (4 - (data_len % 4)) % 4;
        for (i = 0; i < last_pad; i++)
            msg_bytes.push_back(8'($urandom));
    endfunction

    // mostly well-formed messages, the rest malformed, cut short or noise
    task automatic compose_message(output int n_send, output bit noisy);
        int          pick, n_avps, dl, k, start, hlen;
        bit          vendor;
        logic [23:0] len;
        pick = $urandom_range(99);
        n_avps = $urandom_range(0, 4);
        noisy = 1'b0;
        start_header();
        if (pick >= 95) begin
            noisy = 1'b1;
            msg_bytes.delete();
            repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
        end else if (pick >= 55 && pick < 63) begin
            set_msg_len(24'($urandom_range(0, 19)));
            repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom));
        end else begin
            for (k = 0; k < n_avps; k++) begin
                vendor = 1'($urandom_range(1));
                dl = $urandom_range(0, 13);
                add_avp(24'((vendor ? 12 : 8) + dl), dl, vendor);
            end
            start = msg_bytes.size();
            vendor = 1'($urandom_range(1));
            dl = $urandom_range(0, 13);
            hlen = vendor ? 12 : 8;
            if (pick < 55) begin
                len = 24'(msg_bytes.size());
                if (last_pad != 0 && $urandom_range(2) == 0)
                    len = 24'(msg_bytes.size() - last_pad);
            end else if (pick < 71) begin
                add_avp(24'($urandom_range(0, hlen - 1)), $urandom_range(0, 4), vendor);
                repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom));
                len = 24'(msg_bytes.size());
            end else if (pick < 79) begin
                if ($urandom_range(3) == 0)
                    add_avp(24'hffffff, dl, vendor);
                else
                    add_avp(24'(hlen + dl + $urandom_range(1, 600)), dl, vendor);
                len = 24'(msg_bytes.size());
            end else if (pick < 85) begin
                add_avp(24'(hlen + dl), dl, vendor);
                len = 24'(start + $urandom_range(1, hlen - 1));
            end else if (pick < 90) begin
                len = 24'(msg_bytes.size());
            end else begin
                len = 24'($urandom_range(20, 24'hffffff));
            end
            set_msg_len(len);
        end
        n_send = msg_bytes.size();
        if (pick >= 85 && pick < 90)
            n_send = $urandom_range(1, n_send - 1);
    endtask

    // more AVPs than the block tracks, ending in a short AVP length
    function automatic void compose_crowded();
        int k, dl;
        bit vendor;
        start_header();
        for (k = 0; k < 66; k++) begin
            dl = (k % 8 == 5) ? $urandom_range(1, 5) : 0;
            vendor = (k % 16 == 3);
            add_avp(24'((vendor ? 12 : 8) + dl), dl, vendor);
        end
        add_avp(24'd3, 0, 1'b0);
        repeat (4) msg_bytes.push_back(8'($urandom));
        set_msg_len(24'(msg_bytes.size()));
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic f, input logic typed,
                             input t_result want_in);
        t_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_first_byte <= f;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        r = deframe_byte(b, f);
        sent_beats++;
        fields_due.push_back(typed ? want_in : r);
    endtask

    always @(posedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_kind, o_value, o_avp_number, o_end_of_avp, o_end_of_message,
                   o_error_code};
            if (fields_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: kind=%0d value=%h avp=%0d eoa=%b eom=%b err=%0d",
                         $time, got.kind, got.value, got.avp_number, got.end_of_avp,
                         got.end_of_message, got.err);
            end else begin
                want = fields_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: mismatch: expected kind=%0d value=%h avp=%0d eoa=%b eom=%b err=%0d",
                             $time, want.kind, want.value, want.avp_number, want.end_of_avp,
                             want.end_of_message, want.err);
                    $display("%0t:           actual kind=%0d value=%h avp=%0d eoa=%b eom=%b err=%0d",
                             $time, got.kind, got.value, got.avp_number, got.end_of_avp,
                             got.end_of_message, got.err);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL diameter_message_deframer");
            $finish;
        end
    end

    initial begin : main
        int i, n_send;
        bit noisy, crowded_sent;
        crowded_sent = 1'b0;
        // idle byte, short length, resync, then a 20-byte header-only message
        add_row(8'hff, 1'b0, 1'b1, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h01, 1'b1, 1'b1, KIND_VERSION,    32'd1,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h13, 1'b0, 1'b1, KIND_ERROR,      32'd19,         1'b0, ERR_MSG_SHORT);
        add_row(8'ha5, 1'b0, 1'b1, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b1, 1'b1, KIND_VERSION,    32'hff,         1'b0, ERR_NONE);
        add_row(8'h00, 1'b1, 1'b1, KIND_VERSION,    32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h14, 1'b0, 1'b1, KIND_MSG_LENGTH, 32'd20,         1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b1, KIND_FLAGS,      32'hff,         1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b1, KIND_COMMAND,    32'hffffff,     1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b1, KIND_APP_ID,     32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'hff, 1'b0, 1'b1, KIND_HOP_ID,     32'hffffffff,   1'b0, ERR_NONE);
        add_row(8'h80, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h00, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h7f, 1'b0, 1'b0, KIND_NONE,       32'd0,          1'b0, ERR_NONE);
        add_row(8'h01, 1'b0, 1'b1, KIND_E2E_ID,     32'h80007f01,   1'b1, ERR_NONE);
        add_row(8'h55, 1'b0, 1'b1, KIND_NONE,       32'd0,          1'b0, ERR_NONE);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 27;
        rx_idle_pct = 65;
        for (i = 0; i < script.size(); i++)
            send_beat(script[i].b, script[i].f, script[i].typed, script[i].want);

        while (sent_beats < 900) begin
            if (sent_beats >= 300) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (sent_beats >= 150) begin
                tx_idle_pct = 65;
                rx_idle_pct = 27;
            end
            if (sent_beats >= 300 && !crowded_sent) begin
                crowded_sent = 1'b1;
                hold_go <= 1'b1;
                compose_crowded();
                n_send = msg_bytes.size();
                noisy = 1'b0;
            end else begin
                compose_message(n_send, noisy);
            end
            for (i = 0; i < n_send; i++)
                send_beat(msg_bytes[i], noisy ? ($urandom_range(15) == 0) : (i == 0),
                          1'b0, '0);
        end
        i_valid <= 1'b0;

        while (fields_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS diameter_message_deframer");
        else
            $display("FAIL diameter_message_deframer");
        $finish;
    end

endmodule

>>> diameter_message_deframer.f
+incdir+sv
sv/dmd_pkg.sv
sv/dmd_parser.sv
sv/diameter_message_deframer.sv
dv/tb_diameter_message_deframer.sv
